// ===== design/html_text_cleaner_core_assert.svh =====
// assertion macros shared by the html text cleaner rtl
// depends on clk_i and rst_ni being in scope where a macro is used
`ifndef HTML_TEXT_CLEANER_CORE_ASSERT_SVH
`define HTML_TEXT_CLEANER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define HTC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("htc assertion failed");
// expression must never be true at a clock edge outside reset
`define HTC_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("htc forbidden condition seen");
`else
`define HTC_ASSERT(name, prop)
`define HTC_ASSERT_NEVER(name, expr)
`endif
`endif

// ===== design/htc_pkg.sv =====
// types, constants and entity tables for the html text cleaner
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package htc_pkg;

  localparam int unsigned NUM_ENT      = 7;
  localparam int unsigned MAX_CHARS    = 7;
  localparam int unsigned PREFIX_DEPTH = 4;
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef logic [7:0] char_t;

  localparam char_t CH_AMP   = 8'h26;
  localparam char_t CH_LT    = 8'h3c;
  localparam char_t CH_GT    = 8'h3e;
  localparam char_t CH_QUOT  = 8'h22;
  localparam char_t CH_APOS  = 8'h27;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_NONE  = 8'h00;

  localparam logic [NUM_ENT-1:0] ALL_CANDS = '1;

  // register index of max_output_chars
  localparam logic REG_MAX_OUTPUT = 1'b0;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_TAG  = 2'd1,
    MODE_ENT  = 2'd2
  } scan_mode_e;

  // one request from the front to the back: candidate characters in order
  typedef struct packed {
    char_t [MAX_CHARS-1:0] chars;
    logic  [2:0]           cnt;
    logic                  last;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // entity body length including the semicolon
  function automatic logic [2:0] ent_len(input logic [2:0] e);
    logic [2:0] len;
    unique case (e)
      3'd0:    len = 3'd4;
      3'd1:    len = 3'd3;
      3'd2:    len = 3'd3;
      3'd3:    len = 3'd5;
      3'd4:    len = 3'd4;
      3'd5:    len = 3'd5;
      3'd6:    len = 3'd5;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // byte at position pos of the entity body after the ampersand
  function automatic char_t ent_char(input logic [2:0] e, input logic [2:0] pos);
    logic [39:0] word;
    char_t       ch;
    unique case (e)
      3'd0:    word = {"amp;", 8'h00};
      3'd1:    word = {"lt;", 16'h0000};
      3'd2:    word = {"gt;", 16'h0000};
      3'd3:    word = "quot;";
      3'd4:    word = {"#39;", 8'h00};
      3'd5:    word = "apos;";
      3'd6:    word = "nbsp;";
      default: word = '0;
    endcase
    ch = CH_NONE;
    for (int i = 0; i < 5; i++) begin
      if (pos == 3'(i)) begin
        ch = word[8*(4-i) +: 8];
      end
    end
    return ch;
  endfunction

  // decoded value; zero marks the non-breaking space, which acts as whitespace
  function automatic char_t ent_val(input logic [2:0] e);
    char_t v;
    unique case (e)
      3'd0:    v = CH_AMP;
      3'd1:    v = CH_LT;
      3'd2:    v = CH_GT;
      3'd3:    v = CH_QUOT;
      3'd4:    v = CH_APOS;
      3'd5:    v = CH_APOS;
      default: v = CH_NONE;
    endcase
    return v;
  endfunction

  function automatic logic is_space(input char_t b);
    return b == CH_SPACE || b == 8'h09 || b == 8'h0a || b == 8'h0d ||
           b == 8'h0c || b == 8'h0b;
  endfunction

endpackage

// ===== design/htc_front.sv =====
// front end: accepts markup bytes, tracks tag and entity scanning,
// and turns each byte into a request of candidate characters; uses htc_pkg
`timescale 1ns / 1ps
`include "html_text_cleaner_core_assert.svh"
module htc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           end_of_text_i,
  input  logic           lim_nz_i,
  input  htc_pkg::qstat_t qstat_i,
  output logic           push_o,
  output htc_pkg::job_t  job_o
);
  import htc_pkg::*;

  scan_mode_e            mode_q, mode_d;
  logic [2:0]            plen_q, plen_d;
  logic [NUM_ENT-1:0]    cand_q, cand_d;
  logic                  space_owed_q, space_owed_d;
  logic                  kept_any_q, kept_any_d;
  char_t [PREFIX_DEPTH-1:0] prefix_q;

  logic                  acc;
  logic [NUM_ENT-1:0]    live;
  logic                  hit_any;
  logic [2:0]            hit_idx;
  char_t                 hit_val;
  logic                  pre_wr;
  logic                  text_en;
  logic                  hit_vis;
  logic                  nbsp_space;
  logic                  tb_vis;
  logic                  tb_space;
  char_t                 tb_char;
  char_t                 single_char;
  logic [2:0]            rc;
  logic [2:0]            vis_n;
  logic                  sp;
  logic                  kept_any_mid;
  logic [2:0]            slot;
  logic [2:0]            pidx;

  assign in_ready_o = !qstat_i.full;
  assign acc        = in_valid_i && in_ready_o;

  // entity candidate match against the byte at the current prefix position
  always_comb begin
    live    = '0;
    hit_any = 1'b0;
    hit_idx = '0;
    for (int e = 0; e < NUM_ENT; e++) begin
      if (cand_q[e] && plen_q < ent_len(3'(e)) &&
          ent_char(3'(e), plen_q) == in_byte_i) begin
        if ({1'b0, plen_q} + 4'd1 == {1'b0, ent_len(3'(e))}) begin
          hit_any = 1'b1;
          hit_idx = 3'(e);
        end else begin
          live[e] = 1'b1;
        end
      end
    end
    hit_val = ent_val(hit_idx);
  end

  // next scan state and the request for this byte
  always_comb begin
    mode_d       = mode_q;
    plen_d       = plen_q;
    cand_d       = cand_q;
    space_owed_d = space_owed_q;
    kept_any_d   = kept_any_q;
    pre_wr       = 1'b0;
    rc           = '0;
    text_en      = 1'b0;
    hit_vis      = 1'b0;
    nbsp_space   = 1'b0;
    tb_vis       = 1'b0;
    tb_space     = 1'b0;
    tb_char      = in_byte_i;

    unique case (mode_q)
      MODE_TAG: begin
        if (in_byte_i == CH_GT) begin
          mode_d = MODE_TEXT;
        end
      end
      MODE_ENT: begin
        if (hit_any) begin
          mode_d = MODE_TEXT;
          plen_d = '0;
          cand_d = ALL_CANDS;
          if (hit_val == CH_NONE) begin
            nbsp_space = 1'b1;
          end else begin
            hit_vis = 1'b1;
          end
        end else if (live != '0 && !end_of_text_i && plen_q < 3'(PREFIX_DEPTH)) begin
          pre_wr = 1'b1;
          plen_d = plen_q + 3'd1;
          cand_d = live;
        end else begin
          // mismatch: replay ampersand and prefix, then treat byte as text
          mode_d  = MODE_TEXT;
          rc      = plen_q + 3'd1;
          plen_d  = '0;
          cand_d  = ALL_CANDS;
          text_en = 1'b1;
        end
      end
      default: begin
        mode_d  = MODE_TEXT;
        text_en = 1'b1;
      end
    endcase

    // plain text handling of the byte
    if (text_en) begin
      if (in_byte_i == CH_LT) begin
        mode_d = MODE_TAG;
      end else if (in_byte_i == CH_AMP) begin
        if (end_of_text_i) begin
          tb_vis = 1'b1;
        end else begin
          mode_d = MODE_ENT;
          plen_d = '0;
          cand_d = ALL_CANDS;
        end
      end else if (is_space(in_byte_i)) begin
        tb_space = 1'b1;
      end else begin
        tb_vis = 1'b1;
      end
    end

    vis_n        = rc + {2'b00, hit_vis} + {2'b00, tb_vis};
    sp           = space_owed_q && vis_n != '0;
    kept_any_mid = kept_any_q || (lim_nz_i && rc != '0);
    single_char  = hit_vis ? hit_val : tb_char;

    // whitespace bookkeeping
    if (vis_n != '0) begin
      space_owed_d = 1'b0;
    end
    if (tb_space || nbsp_space) begin
      space_owed_d = kept_any_mid;
    end
    kept_any_d = kept_any_q || (lim_nz_i && vis_n != '0);

    // fragment end returns the scanner to its initial state
    if (end_of_text_i) begin
      mode_d       = MODE_TEXT;
      plen_d       = '0;
      cand_d       = ALL_CANDS;
      space_owed_d = 1'b0;
      kept_any_d   = 1'b0;
    end

    // assemble candidate characters: owed space, replay, single char
    for (int k = 0; k < MAX_CHARS; k++) begin
      slot = 3'(k) - {2'b00, sp};
      pidx = slot - 3'd1;
      if (sp && k == 0) begin
        job_o.chars[k] = CH_SPACE;
      end else if (slot == '0 && rc != '0) begin
        job_o.chars[k] = CH_AMP;
      end else if (slot < rc) begin
        job_o.chars[k] = prefix_q[pidx[1:0]];
      end else begin
        job_o.chars[k] = single_char;
      end
    end
    job_o.cnt  = vis_n + {2'b00, sp};
    job_o.last = end_of_text_i;
    push_o     = acc && (job_o.cnt != '0 || end_of_text_i);
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_TEXT;
      plen_q       <= '0;
      cand_q       <= ALL_CANDS;
      space_owed_q <= 1'b0;
      kept_any_q   <= 1'b0;
    end else if (acc) begin
      mode_q       <= mode_d;
      plen_q       <= plen_d;
      cand_q       <= cand_d;
      space_owed_q <= space_owed_d;
      kept_any_q   <= kept_any_d;
    end
  end

  // entity prefix store
  always_ff @(posedge clk_i) begin
    if (acc && pre_wr) begin
      prefix_q[plen_q[1:0]] <= in_byte_i;
    end
  end

  `HTC_ASSERT_NEVER(prefix_len_range, plen_q > 3'(PREFIX_DEPTH))
  `HTC_ASSERT_NEVER(entity_without_cands, mode_q == MODE_ENT && cand_q == '0)

endmodule

// ===== design/htc_queue.sv =====
// short request queue between the front end and the emitter
// holds htc_pkg::job_t entries in registers; uses htc_pkg
`timescale 1ns / 1ps
`include "html_text_cleaner_core_assert.svh"
module htc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  htc_pkg::job_t   job_i,
  input  logic            pop_i,
  output htc_pkg::job_t   head_o,
  output htc_pkg::qstat_t qstat_o
);
  import htc_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q, count_d;

  assign head_o        = entry_q[rd_ptr_q];
  assign qstat_o.empty = count_q == '0;
  assign qstat_o.full  = count_q == CW'(QUEUE_DEPTH);

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  `HTC_ASSERT_NEVER(push_when_full, push_i && qstat_o.full)

endmodule

// ===== design/htc_back.sv =====
// emitter: walks queued requests one character per cycle unless stalled,
// applies capacity limit, drives the registered result channel; uses htc_pkg
`timescale 1ns / 1ps
`include "html_text_cleaner_core_assert.svh"
module htc_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     cfg_max_i,
  input  htc_pkg::job_t   head_i,
  input  htc_pkg::qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            char_valid_o,
  output logic            run_last_o,
  output logic            text_done_o,
  output logic            text_complete_o
);
  import htc_pkg::*;

  localparam int unsigned LW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  logic [COUNT_BITS-1:0] kept_q, kept_d;
  logic                  all_fit_q, all_fit_d;
  logic [2:0]            idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  char_t                 out_char_q, out_char_d;
  logic                  char_valid_q, char_valid_d;
  logic                  run_last_q, run_last_d;
  logic                  text_done_q, text_done_d;
  logic                  text_complete_q, text_complete_d;

  logic [LW-1:0] kept_x, kept_inc, max_x, cap_x, lim_x;
  logic          room, room_next, is_final, hv, can_out, load;
  logic          emit_empty, emit_char, silent, fit_now;
  logic [2:0]    last_idx;

  always_comb begin
    // capacity: smaller of the register and the counter range
    kept_x    = LW'(kept_q);
    kept_inc  = kept_x + LW'(1);
    max_x     = LW'(cfg_max_i);
    cap_x     = LW'({COUNT_BITS{1'b1}});
    lim_x     = (max_x < cap_x) ? max_x : cap_x;
    room      = kept_x < lim_x;
    room_next = kept_inc < lim_x;

    hv         = !qstat_i.empty;
    last_idx   = head_i.cnt - 3'd1;
    is_final   = idx_q == last_idx || !room_next;
    emit_empty = hv && (head_i.cnt == '0 || (!room && head_i.last));
    emit_char  = hv && head_i.cnt != '0 && room;
    silent     = hv && head_i.cnt != '0 && !room && !head_i.last;
    can_out    = !out_valid_q || out_ready_i;
    fit_now    = all_fit_q && !(is_final && idx_q != last_idx);

    kept_d          = kept_q;
    all_fit_d       = all_fit_q;
    idx_d           = idx_q;
    pop_o           = 1'b0;
    load            = 1'b0;
    out_valid_d     = out_valid_q && !out_ready_i;
    out_char_d      = out_char_q;
    char_valid_d    = char_valid_q;
    run_last_d      = run_last_q;
    text_done_d     = text_done_q;
    text_complete_d = text_complete_q;

    if (emit_empty && can_out) begin
      // fragment end with nothing kept for this byte
      pop_o           = 1'b1;
      load            = 1'b1;
      out_char_d      = CH_NONE;
      char_valid_d    = 1'b0;
      run_last_d      = 1'b1;
      text_done_d     = 1'b1;
      text_complete_d = all_fit_q && head_i.cnt == '0;
      kept_d          = '0;
      all_fit_d       = 1'b1;
      idx_d           = '0;
    end else if (emit_char && can_out) begin
      // kept character; the rest of the request drops once room runs out
      load            = 1'b1;
      out_char_d      = head_i.chars[idx_q];
      char_valid_d    = 1'b1;
      run_last_d      = is_final;
      text_done_d     = is_final && head_i.last;
      text_complete_d = is_final && head_i.last && fit_now;
      if (is_final) begin
        pop_o = 1'b1;
        idx_d = '0;
        if (head_i.last) begin
          kept_d    = '0;
          all_fit_d = 1'b1;
        end else begin
          kept_d    = kept_q + COUNT_BITS'(1);
          all_fit_d = fit_now;
        end
      end else begin
        idx_d  = idx_q + 3'd1;
        kept_d = kept_q + COUNT_BITS'(1);
      end
    end else if (silent) begin
      // buffer already full: drop the whole request
      pop_o     = 1'b1;
      all_fit_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q      <= '0;
      all_fit_q   <= 1'b1;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      kept_q      <= kept_d;
      all_fit_q   <= all_fit_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    out_char_q      <= out_char_d;
    char_valid_q    <= char_valid_d;
    run_last_q      <= run_last_d;
    text_done_q     <= text_done_d;
    text_complete_q <= text_complete_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign char_valid_o    = char_valid_q;
  assign run_last_o      = run_last_q;
  assign text_done_o     = text_done_q;
  assign text_complete_o = text_complete_q;

  `HTC_ASSERT_NEVER(done_without_last, out_valid_q && text_done_q && !run_last_q)
  `HTC_ASSERT_NEVER(complete_without_done, out_valid_q && text_complete_q && !text_done_q)
  `HTC_ASSERT(empty_result_ends_text, (out_valid_q && !char_valid_q) |-> text_done_q)

endmodule

// ===== design/html_text_cleaner_core.sv =====
// top level of the html text cleaner: register port, front end, queue, emitter
// depends on htc_pkg, htc_front, htc_queue and htc_back
`timescale 1ns / 1ps
// Usage
//   Markup bytes enter on the in_ channel (valid/ready) with end_of_text_i on
//   the final byte of a fragment. Cleaned characters leave on the out_
//   channel, at most one character per result, with run_last_o on the last
//   result of each byte and text_done_o / text_complete_o on the final one.
//   max_output_chars sits at byte address 0 of the APB port (reset 255).
// Timing
//   The front end takes one byte per cycle while its four-entry queue has
//   room. The emitter sends one result per cycle while out_ready_i allows;
//   a byte can cause up to 7 results (for a replayed entity prefix), and
//   bytes with no result do not occupy the emitter unless they are dropped
//   for capacity. With the queue empty and the result register free, the
//   first result of a byte is loaded at the edge after the one that
//   accepted it.
// Reset and stalls
//   Reset returns to plain text mode with an empty queue, no owed space and
//   capacity 255. When the receiver holds out_ready_i low the result
//   register holds, the queue fills and in_ready_o falls once it is full.
module html_text_cleaner_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        char_valid_o,
  output logic        run_last_o,
  output logic        text_done_o,
  output logic        text_complete_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import htc_pkg::*;

  logic [15:0] cfg_max_q;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  job_t        job_in;
  job_t        job_head;
  qstat_t      qstat;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && paddr[2] == REG_MAX_OUTPUT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_max_q <= 16'd255;
    end else if (cfg_wr) begin
      cfg_max_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_OUTPUT) begin
      prdata = {16'h0000, cfg_max_q};
    end
  end

  // byte scanner
  htc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .lim_nz_i      (cfg_max_q != 16'd0),
    .qstat_i       (qstat),
    .push_o        (push),
    .job_o         (job_in)
  );

  // request queue
  htc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .head_o  (job_head),
    .qstat_o (qstat)
  );

  // character emitter
  htc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_max_i       (cfg_max_q),
    .head_i          (job_head),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_o      (out_char_o),
    .char_valid_o    (char_valid_o),
    .run_last_o      (run_last_o),
    .text_done_o     (text_done_o),
    .text_complete_o (text_complete_o)
  );

endmodule
